// ===== design/bffa_pkg.sv =====
// Package for the bitmap first-free allocator.
// Holds the request and response transaction types and the operation and status codes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bffa_pkg;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_MARK    = 2'd2;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_NONE  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam logic CSR_ENTRIES = 1'b0;
   localparam logic CSR_BASE    = 1'b1;

   localparam logic [15:0] ENTRIES_RESET = 16'h8000;

   typedef struct packed {
      logic [1:0]  op;
      logic [14:0] index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [14:0] slot;
      logic [31:0] address;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/bitmap_first_free_allocator_top.sv =====
// Top level of the bitmap first-free allocator.
// Holds the bitmap and the full-word summary memories and the sequencer around them.
// Depends on bffa_pkg.
//
// Usage. A transaction is taken on req_data when start is high and busy is low.
// Each transaction yields one response on rsp_data, shown for exactly one cycle
// with rsp_valid high; the receiver cannot hold it off, so it must take it then.
// The configuration registers are written through csr_we, csr_index and csr_wdata
// while the block is idle. Index 0 is the entry count, index 1 the base address.
// Sequence. An index out of range or an unused operation answers in the cycle after
// acceptance. Release and mark read one bitmap word and one summary word on acceptance
// and write both back in the update state, which also sets the response. Allocate scans
// the summary memory, which has one bit per bitmap word that is set when that word is full,
// with a request state and a check state per summary word, then reads one bitmap word
// and answers. Both memories are single-port.
// Reset. After reset the block clears both memories, one word per cycle, and holds
// busy high meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_first_free_allocator_top #(
   parameter int CAPACITY = 32768
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  bffa_pkg::req_type     req_data,
   output logic                  rsp_valid,
   output bffa_pkg::rsp_type     rsp_data,
   input  wire                   csr_we,
   input  wire                   csr_index,
   input  wire  [31:0]           csr_wdata
);

   import bffa_pkg::*;

   localparam int WORD_COUNT = (CAPACITY + 31) / 32;
   localparam int SUM_COUNT  = (WORD_COUNT + 31) / 32;
   localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int SUM_AW     = (SUM_COUNT > 1) ? $clog2(SUM_COUNT) : 1;
   localparam int SUM_CW     = $clog2(SUM_COUNT + 1);
   localparam logic [15:0] CAP_CLIP = (CAPACITY > 65535) ? 16'hFFFF : 16'(CAPACITY);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_SUM_REQ  = 3'd2;
   localparam logic [2:0] S_SUM_CHK  = 3'd3;
   localparam logic [2:0] S_WORD_CHK = 3'd4;
   localparam logic [2:0] S_UPD      = 3'd5;

   function automatic logic [4:0] low_zero(input logic [31:0] v);
      logic [4:0] r;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         if (!v[i]) begin
            r = 5'(i);
         end
      end
      return r;
   endfunction

   logic [31:0] word_mem [WORD_COUNT];
   logic [31:0] sum_mem [SUM_COUNT];

   logic [2:0]         state_ff, state_in;
   logic [WORD_AW-1:0] clr_ff, clr_in;
   logic [1:0]         op_ff, op_in;
   logic [14:0]        idx_ff, idx_in;
   logic [SUM_CW-1:0]  scan_ff, scan_in;
   logic [WORD_AW-1:0] widx_ff, widx_in;
   logic [4:0]         sbit_ff, sbit_in;
   logic [31:0]        sum_ff, sum_in;
   logic [15:0]        entries_ff;
   logic [31:0]        base_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [31:0]        word_q, sum_q;

   logic               word_re, word_we, sum_re, sum_we;
   logic [WORD_AW-1:0] word_addr;
   logic [SUM_AW-1:0]  sum_addr;
   logic [31:0]        word_wdata, sum_wdata;

   logic [15:0]        limit;
   logic [4:0]         zero_bit;
   logic [31:0]        word_wide, pos_wide, new_word;
   logic [4:0]         upd_sbit;

   assign limit = (entries_ff < CAP_CLIP) ? entries_ff : CAP_CLIP;
   assign zero_bit = (state_ff == S_SUM_CHK) ? low_zero(sum_q) : low_zero(word_q);
   assign word_wide = ((32'(scan_ff)) << 5) | 32'(zero_bit);
   assign pos_wide = ((32'(widx_ff)) << 5) | 32'(zero_bit);
   assign upd_sbit = idx_ff[9:5];
   assign new_word = (op_ff == OP_RELEASE) ? (word_q & ~(32'd1 << idx_ff[4:0]))
                                           : (word_q | (32'd1 << idx_ff[4:0]));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      scan_in      = scan_ff;
      widx_in      = widx_ff;
      sbit_in      = sbit_ff;
      sum_in       = sum_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      word_re      = 1'b0;
      word_we      = 1'b0;
      word_addr    = '0;
      word_wdata   = '0;
      sum_re       = 1'b0;
      sum_we       = 1'b0;
      sum_addr     = '0;
      sum_wdata    = '0;
      case (state_ff)
         S_CLEAR: begin
            word_we   = 1'b1;
            word_addr = clr_ff;
            sum_we    = (32'(clr_ff) < 32'(SUM_COUNT));
            sum_addr  = SUM_AW'(clr_ff);
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == WORD_AW'(WORD_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            word_re   = 1'b1;
            word_addr = WORD_AW'(req_data.index >> 5);
            sum_re    = 1'b1;
            sum_addr  = SUM_AW'(req_data.index >> 10);
            if (start) begin
               op_in  = req_data.op;
               idx_in = req_data.index;
               if (req_data.op == OP_ALLOC) begin
                  scan_in  = '0;
                  state_in = S_SUM_REQ;
               end else if ((req_data.op != OP_RELEASE && req_data.op != OP_MARK) ||
                            (16'(req_data.index) >= limit)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STATUS_RANGE, slot: '0, address: '0};
               end else begin
                  state_in = S_UPD;
               end
            end
         end
         S_SUM_REQ: begin
            if ((32'(scan_ff) == 32'(SUM_COUNT)) ||
                (((32'(scan_ff)) << 10) >= 32'(limit))) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_NONE, slot: '0, address: '0};
               state_in     = S_IDLE;
            end else begin
               sum_re   = 1'b1;
               sum_addr = SUM_AW'(scan_ff);
               state_in = S_SUM_CHK;
            end
         end
         S_SUM_CHK: begin
            if (sum_q != 32'hFFFF_FFFF) begin
               if ((word_wide << 5) >= 32'(limit)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: STATUS_NONE, slot: '0, address: '0};
                  state_in     = S_IDLE;
               end else begin
                  word_re   = 1'b1;
                  word_addr = WORD_AW'(word_wide);
                  widx_in   = WORD_AW'(word_wide);
                  sbit_in   = zero_bit;
                  sum_in    = sum_q;
                  state_in  = S_WORD_CHK;
               end
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_SUM_REQ;
            end
         end
         S_WORD_CHK: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (pos_wide >= 32'(limit)) begin
               rsp_in = '{status: STATUS_NONE, slot: '0, address: '0};
            end else begin
               word_we    = 1'b1;
               word_addr  = widx_ff;
               word_wdata = word_q | (32'd1 << zero_bit);
               sum_we     = 1'b1;
               sum_addr   = SUM_AW'(scan_ff);
               sum_wdata  = sum_ff;
               sum_wdata[sbit_ff] = ((word_q | (32'd1 << zero_bit)) == 32'hFFFF_FFFF);
               rsp_in = '{status: STATUS_DONE, slot: pos_wide[14:0],
                          address: base_ff + pos_wide};
            end
         end
         S_UPD: begin
            state_in     = S_IDLE;
            word_we      = 1'b1;
            word_addr    = WORD_AW'(idx_ff >> 5);
            word_wdata   = new_word;
            sum_we       = 1'b1;
            sum_addr     = SUM_AW'(idx_ff >> 10);
            sum_wdata    = sum_q;
            sum_wdata[upd_sbit] = (new_word == 32'hFFFF_FFFF);
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: STATUS_DONE, slot: idx_ff,
                             address: base_ff + 32'(idx_ff)};
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[word_addr] <= word_wdata;
      end
      if (word_re) begin
         word_q <= word_mem[word_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_addr] <= sum_wdata;
      end
      if (sum_re) begin
         sum_q <= sum_mem[sum_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         entries_ff   <= ENTRIES_RESET;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_ENTRIES) begin
            entries_ff <= csr_wdata[15:0];
         end
         if (csr_we && csr_index == CSR_BASE) begin
            base_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      idx_ff  <= idx_in;
      scan_ff <= scan_in;
      widx_ff <= widx_in;
      sbit_ff <= sbit_in;
      sum_ff  <= sum_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for bitmap_first_free_allocator_top.
// Drives allocate, release and mark transactions under several register settings and
// checks every response against a bitmap predictor kept here. Depends on bffa_pkg.
`timescale 1ns / 1ps

module tb_top;
   import bffa_pkg::*;

   localparam int CAPACITY = 32768;
   localparam int WORDS = CAPACITY / 32;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = CSR_ENTRIES;
   logic [31:0] csr_wdata = '0;

   logic [31:0] usage_words [WORDS];
   logic [15:0] entry_count = ENTRIES_RESET;
   logic [31:0] base_addr = '0;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int gap_chance = 0;
   int gap_left = 0;
   int accepted_count = 0;
   int mismatches = 0;
   int done_count = 0;
   int none_count = 0;
   int range_count = 0;
   int cycle_count = 0;

   bitmap_first_free_allocator_top #(.CAPACITY(CAPACITY)) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bitmap_first_free_allocator_top test failed");
         $finish;
      end
   end

   function automatic int unsigned active_limit();
      return (entry_count > CAPACITY) ? CAPACITY : entry_count;
   endfunction

   function automatic rsp_type predict_response(req_type rq);
      rsp_type rs;
      int unsigned lim;
      int unsigned pos;
      bit scanning;
      bit hit;
      rs = '0;
      lim = active_limit();
      hit = 1'b0;
      if (rq.op == OP_ALLOC) begin
         scanning = 1'b1;
         pos = 0;
         for (int w = 0; w < WORDS && scanning; w++) begin
            if (w * 32 >= lim) begin
               scanning = 1'b0;
            end else if (usage_words[w] != '1) begin
               for (int b = 31; b >= 0; b--)
                  if (!usage_words[w][b]) pos = w * 32 + b;
               scanning = 1'b0;
               if (pos < lim) begin
                  usage_words[w][pos % 32] = 1'b1;
                  hit = 1'b1;
               end
            end
         end
         if (!hit) rs.status = STATUS_NONE;
      end else if (rq.op == OP_UNUSED || rq.index >= lim) begin
         rs.status = STATUS_RANGE;
      end else begin
         pos = rq.index;
         usage_words[pos / 32][pos % 32] = (rq.op == OP_MARK);
         hit = 1'b1;
      end
      if (hit) begin
         rs.status = STATUS_DONE;
         rs.slot = pos[14:0];
         rs.address = base_addr + pos;
      end
      return rs;
   endfunction

   always @(posedge clock) begin : driver
      bit ready_for_next;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         ready_for_next = 1'b1;
         if (start) begin
            if (busy === 1'b0) begin
               expected_rsps.push_back(predict_response(req_data));
               accepted_count++;
            end else begin
               ready_for_next = 1'b0;
            end
         end
         if (ready_for_next) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               if ($urandom_range(1, 100) <= gap_chance) begin
                  gap_left = $urandom_range(0, 14);
                  start <= 1'b0;
               end else begin
                  req_data <= pending_reqs.pop_front();
                  start <= 1'b1;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response: status %0d slot %0d address %h",
                   rsp_data.status, rsp_data.slot, rsp_data.address);
            mismatches++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.slot !== want.slot) begin
               $error("slot: expected %0d, actual %0d", want.slot, rsp_data.slot);
               mismatches++;
            end
            if (rsp_data.address !== want.address) begin
               $error("address: expected %h, actual %h", want.address, rsp_data.address);
               mismatches++;
            end
            case (want.status)
               STATUS_DONE: done_count++;
               STATUS_NONE: none_count++;
               default: range_count++;
            endcase
         end
      end
   end

   task automatic queue_req(input logic [1:0] op, input int unsigned idx);
      req_type rq;
      rq.op = op;
      rq.index = idx[14:0];
      pending_reqs.push_back(rq);
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0 || busy !== 1'b0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [31:0] entries_raw, input logic [31:0] base);
      wait_idle();
      write_csr(CSR_ENTRIES, entries_raw);
      entry_count = entries_raw[15:0];
      write_csr(CSR_BASE, base);
      base_addr = base;
   endtask

   task automatic queue_mixed(input int count, input int alloc_pct, input int unsigned span);
      int unsigned lim;
      int unsigned reach;
      int unsigned idx;
      int r;
      int pick;
      logic [1:0] op;
      lim = active_limit();
      reach = (lim < span) ? lim : span;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         pick = $urandom_range(0, 9);
         if (reach > 0 && pick < 7) idx = $urandom_range(0, reach - 1);
         else if (pick == 7 && lim < CAPACITY) idx = lim;
         else idx = $urandom_range(0, CAPACITY - 1);
         if (r < alloc_pct) op = OP_ALLOC;
         else if (r < alloc_pct + (100 - alloc_pct) * 45 / 100) op = OP_RELEASE;
         else if (r < alloc_pct + (100 - alloc_pct) * 90 / 100) op = OP_MARK;
         else op = OP_UNUSED;
         queue_req(op, idx);
      end
   endtask

   task automatic pick_gaps();
      case ($urandom_range(0, 2))
         0: gap_chance = 0;
         1: gap_chance = 20;
         default: gap_chance = 40;
      endcase
   endtask

   initial begin
      for (int w = 0; w < WORDS; w++) usage_words[w] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);

      gap_chance = 30;
      queue_req(OP_ALLOC, 0);
      queue_req(OP_ALLOC, 15'h7fff);
      queue_req(OP_ALLOC, 0);
      queue_req(OP_RELEASE, 1);
      queue_req(OP_ALLOC, 0);
      queue_req(OP_MARK, 32767);
      queue_req(OP_RELEASE, 32767);
      queue_req(OP_RELEASE, 32767);
      queue_req(OP_MARK, 5);
      queue_req(OP_MARK, 5);
      queue_req(OP_UNUSED, 32767);
      queue_req(OP_UNUSED, 0);
      queue_req(OP_RELEASE, 0);
      queue_req(OP_ALLOC, 0);

      set_config(32'd0, 32'hffff_fff0);
      queue_req(OP_ALLOC, 0);
      queue_req(OP_RELEASE, 0);
      queue_req(OP_MARK, 0);

      set_config(32'd3, 32'hffff_fffe);
      queue_req(OP_ALLOC, 0);
      queue_req(OP_RELEASE, 2);
      queue_req(OP_ALLOC, 0);
      queue_req(OP_MARK, 3);
      queue_req(OP_UNUSED, 1);

      // The entry count register keeps only its low sixteen bits.
      set_config(32'habcd_0028, $urandom());
      pick_gaps();
      queue_mixed(30, 40, CAPACITY);

      set_config(32'd1, 32'hffff_ffff);
      pick_gaps();
      queue_mixed(20, 40, CAPACITY);

      set_config(32'd33, $urandom());
      pick_gaps();
      queue_mixed(30, 45, CAPACITY);

      set_config(32'd0, $urandom());
      pick_gaps();
      queue_mixed(15, 40, CAPACITY);

      set_config(32'h0000_ffff, 32'd0);
      pick_gaps();
      queue_mixed(40, 40, 2048);

      // Only allocations, so that the bitmap fills past the first summary word.
      set_config(32'd32768, 32'hffff_fc00);
      gap_chance = 25;
      queue_mixed(1000, 100, 1200);
      while (pending_reqs.size() > 300) @(posedge clock);
      gap_chance = 0;

      wait_idle();
      repeat (100) @(posedge clock);

      $display("%0d transactions accepted over eight register settings and the reset values.",
               accepted_count);
      $display("Responses: %0d done, %0d no free entry, %0d out of range.",
               done_count, none_count, range_count);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("bitmap_first_free_allocator_top test passed");
      end else begin
         $display("bitmap_first_free_allocator_top test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bffa_pkg.sv
design/bitmap_first_free_allocator_top.sv
dv/tb_top.sv
